[hw/rtl/tthc_pkg.sv]
// Shared constants, types and arithmetic helpers of the touch to HSV color unit.
package tthc_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned PressW  = 15;
  localparam int unsigned SatW    = 8;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned NumW    = 20;
  localparam int unsigned ProdW   = 18;
  localparam int unsigned WideW   = 28;
  localparam int unsigned SectorW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 15;

  localparam int unsigned FullScale = 1023;
  localparam int unsigned LevelMax  = 255;
  localparam int unsigned HsvFull   = LevelMax * FullScale;

  localparam int unsigned DivStages = 5;
  localparam int unsigned DivBitsPerStage = 2;

  localparam logic [PressW-1:0] PressMinRst = 15'd10;
  localparam logic [PressW-1:0] PressMaxRst = 15'd20000;
  localparam logic [CoordW-1:0] XMinRst     = 10'd140;
  localparam logic [CoordW-1:0] XMaxRst     = 10'd870;
  localparam logic [CoordW-1:0] YMinRst     = 10'd0;
  localparam logic [CoordW-1:0] YMaxRst     = 10'd1023;
  localparam logic [SatW-1:0]   SatRst      = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPressMin = 3'd0,
    CfgPressMax = 3'd1,
    CfgXMin     = 3'd2,
    CfgXMax     = 3'd3,
    CfgYMin     = 3'd4,
    CfgYMax     = 3'd5,
    CfgSat      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SectorW-1:0] sector;
    logic [CoordW-1:0]  frac;
  } hue_t;

  // floor(x / 1023) by folding the 1024 base back onto itself
  function automatic logic [ProdW-1:0] div1023(input logic [WideW-1:0] x);
    logic [17:0] q0;
    logic [18:0] r0;
    logic [8:0]  q1;
    logic [10:0] r1;
    logic        q2;
    logic [10:0] r2;
    logic        c;
    q0 = x[27:10];
    r0 = {9'b0, x[9:0]} + {1'b0, q0};
    q1 = r0[18:10];
    r1 = {1'b0, r0[9:0]} + {2'b0, q1};
    q2 = r1[10];
    r2 = {1'b0, r1[9:0]} + {10'b0, q2};
    c  = (r2 >= 11'(FullScale));
    return q0 + {9'b0, q1} + {17'b0, q2} + {17'b0, c};
  endfunction

  // split 6*pos into sector and fraction of 1023; full scale wraps to sector 0
  function automatic hue_t hue_split(input logic [CoordW-1:0] pos);
    logic [12:0] p6;
    hue_t        h;
    p6 = ({3'b0, pos} << 2) + ({3'b0, pos} << 1);
    if (p6 >= 13'(6 * FullScale)) begin
      h.sector = 3'd0;
      h.frac   = '0;
    end else if (p6 >= 13'(5 * FullScale)) begin
      h.sector = 3'd5;
      h.frac   = 10'(p6 - 13'(5 * FullScale));
    end else if (p6 >= 13'(4 * FullScale)) begin
      h.sector = 3'd4;
      h.frac   = 10'(p6 - 13'(4 * FullScale));
    end else if (p6 >= 13'(3 * FullScale)) begin
      h.sector = 3'd3;
      h.frac   = 10'(p6 - 13'(3 * FullScale));
    end else if (p6 >= 13'(2 * FullScale)) begin
      h.sector = 3'd2;
      h.frac   = 10'(p6 - 13'(2 * FullScale));
    end else if (p6 >= 13'(FullScale)) begin
      h.sector = 3'd1;
      h.frac   = 10'(p6 - 13'(FullScale));
    end else begin
      h.sector = 3'd0;
      h.frac   = p6[9:0];
    end
    return h;
  endfunction

endpackage

[hw/rtl/tthc_div.sv]
// Pipelined restoring divider for the axis scaling, two quotient bits per stage.
module tthc_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tthc_pkg::NumW-1:0]     num_i,
  input  logic [tthc_pkg::CoordW-1:0]   den_i,
  output logic [tthc_pkg::CoordW-1:0]   quot_o
);

  localparam int unsigned S  = tthc_pkg::DivStages;
  localparam int unsigned B  = tthc_pkg::DivBitsPerStage;
  localparam int unsigned NW = tthc_pkg::NumW;
  localparam int unsigned QW = tthc_pkg::CoordW;

  logic [NW-1:0] rem_q [S];
  logic [QW-1:0] den_q [S];
  logic [QW-1:0] quo_q [S];
  logic [NW-1:0] rem_d [S];
  logic [QW-1:0] quo_d [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [NW-1:0] rin;
    logic [QW-1:0] qin;
    logic [QW-1:0] din;

    if (s == 0) begin : g_first
      assign rin = num_i;
      assign qin = '0;
      assign din = den_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign qin = quo_q[s-1];
      assign din = den_q[s-1];
    end

    always_comb begin
      logic [NW-1:0] r;
      logic [QW-1:0] q;
      logic [NW-1:0] t;
      r = rin;
      q = qin;
      for (int j = 0; j < B; j++) begin
        t = NW'(din) << (QW - 1 - s * B - j);
        if (r >= t) begin
          r = r - t;
          q[QW - 1 - s * B - j] = 1'b1;
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= din;
      end
    end
  end

  assign quot_o = quo_q[S-1];

endmodule

[hw/rtl/touch_to_hsv_color_unit.sv]
// Top level of the touch to HSV color unit: touch sample in, scaled position and color out.
//
// Slave stream s_axis_* carries one touch sample per item; tdata packs touch_x,
// touch_y and pressure. A sample whose pressure is not strictly inside the
// pressure window is consumed and produces no result. Every other sample yields
// one result item on m_axis_*: pos_x, pos_y, red, green, blue.
// Configuration writes arrive on cfg_valid_i/cfg_index_i/cfg_data_i, always
// ready; write them only while no item is in flight. Index 7 is ignored.
// Throughput is one item per cycle while the receiver does not stall. An
// accepted sample passes an operand stage, a five stage divider that scales both
// axes in parallel, four color stages and the output register, each registered.
// A receiver stall freezes the whole pipeline together with the output
// register; s_axis_tready drops whenever a result waits on a stalled receiver,
// and nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module touch_to_hsv_color_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // touch_x[9:0], touch_y[19:10], pressure[34:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pos_x[9:0], pos_y[19:10], red[29:22],
                                      // green[39:32], blue[49:42]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tthc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tthc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CW = tthc_pkg::CoordW;
  localparam int unsigned PW = tthc_pkg::ProdW;
  localparam int unsigned LW = tthc_pkg::LevelW;
  localparam int unsigned SW = tthc_pkg::SectorW;
  localparam int unsigned DS = tthc_pkg::DivStages;

  logic [tthc_pkg::PressW-1:0] press_min_q, press_max_q;
  logic [CW-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic [tthc_pkg::SatW-1:0] sat_q;

  logic adv;
  logic in_acc;

  logic [CW-1:0] in_x, in_y;
  logic [tthc_pkg::PressW-1:0] in_p;
  logic in_win;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_min_q <= tthc_pkg::PressMinRst;
      press_max_q <= tthc_pkg::PressMaxRst;
      x_min_q     <= tthc_pkg::XMinRst;
      x_max_q     <= tthc_pkg::XMaxRst;
      y_min_q     <= tthc_pkg::YMinRst;
      y_max_q     <= tthc_pkg::YMaxRst;
      sat_q       <= tthc_pkg::SatRst;
    end else if (cfg_valid_i) begin
      case (tthc_pkg::cfg_idx_e'(cfg_index_i))
        tthc_pkg::CfgPressMin: press_min_q <= cfg_data_i;
        tthc_pkg::CfgPressMax: press_max_q <= cfg_data_i;
        tthc_pkg::CfgXMin:     x_min_q     <= cfg_data_i[CW-1:0];
        tthc_pkg::CfgXMax:     x_max_q     <= cfg_data_i[CW-1:0];
        tthc_pkg::CfgYMin:     y_min_q     <= cfg_data_i[CW-1:0];
        tthc_pkg::CfgYMax:     y_max_q     <= cfg_data_i[CW-1:0];
        tthc_pkg::CfgSat:      sat_q       <= cfg_data_i[tthc_pkg::SatW-1:0];
        default: ;
      endcase
    end
  end

  assign in_x   = s_axis_tdata[9:0];
  assign in_y   = s_axis_tdata[19:10];
  assign in_p   = s_axis_tdata[34:20];
  assign in_win = (in_p > press_min_q) && (in_p < press_max_q);

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  // stage 1: clamp and form divider operands
  function automatic logic [CW+CW+CW-1:0] axis_prep(input logic [CW-1:0] raw,
                                                    input logic [CW-1:0] lo,
                                                    input logic [CW-1:0] hi);
    logic [CW-1:0] c;
    logic [CW-1:0] dx;
    logic [CW-1:0] span;
    logic [2*CW-1:0] num;
    c = (raw > hi) ? hi : raw;
    c = (c < lo) ? lo : c;
    if (hi <= lo) begin
      num  = '0;
      span = CW'(1);
    end else begin
      dx   = c - lo;
      span = hi - lo;
      num  = {dx, {CW{1'b0}}} - {{CW{1'b0}}, dx};
    end
    return {num, span};
  endfunction

  logic v1_q;
  logic [tthc_pkg::NumW-1:0] numx_q, numy_q;
  logic [CW-1:0] denx_q, deny_q;
  logic [tthc_pkg::NumW-1:0] numx_d, numy_d;
  logic [CW-1:0] denx_d, deny_d;

  assign {numx_d, denx_d} = axis_prep(in_x, x_min_q, x_max_q);
  assign {numy_d, deny_d} = axis_prep(in_y, y_min_q, y_max_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q <= numx_d;
      denx_q <= denx_d;
      numy_q <= numy_d;
      deny_q <= deny_d;
    end
  end

  // divider stages
  logic [CW-1:0] px, py;

  tthc_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (numx_q),
    .den_i  (denx_q),
    .quot_o (px)
  );

  tthc_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (numy_q),
    .den_i  (deny_q),
    .quot_o (py)
  );

  logic [DS-1:0] vdiv_q;

  // stage 7: hue split and value products
  tthc_pkg::hue_t hue;
  logic v7_q;
  logic [SW-1:0] sec7_q;
  logic [CW-1:0] g7_q, px7_q, py7_q;
  logic [PW-1:0] vnum7_q, mnum7_q;

  assign hue = tthc_pkg::hue_split(px);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec7_q  <= hue.sector;
      g7_q    <= hue.sector[0] ? hue.frac : (CW'(tthc_pkg::FullScale) - hue.frac);
      px7_q   <= px;
      py7_q   <= py;
      vnum7_q <= (PW'(py) << LW) - PW'(py);
      mnum7_q <= PW'(py) * PW'(LW'(tthc_pkg::LevelMax) - sat_q);
    end
  end

  // stage 8: saturation product, value and minimum levels
  logic v8_q;
  logic [SW-1:0] sec8_q;
  logic [CW-1:0] px8_q, py8_q;
  logic [PW-1:0] satg8_q;
  logic [LW-1:0] lv8_q, lm8_q;
  logic [PW-1:0] vq, mq;

  assign vq = tthc_pkg::div1023(tthc_pkg::WideW'(vnum7_q));
  assign mq = tthc_pkg::div1023(tthc_pkg::WideW'(mnum7_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec8_q  <= sec7_q;
      px8_q   <= px7_q;
      py8_q   <= py7_q;
      satg8_q <= PW'(sat_q) * PW'(g7_q);
      lv8_q   <= vq[LW-1:0];
      lm8_q   <= mq[LW-1:0];
    end
  end

  // stage 9: ramp numerator
  logic v9_q;
  logic [SW-1:0] sec9_q;
  logic [CW-1:0] px9_q, py9_q;
  logic [LW-1:0] lv9_q, lm9_q;
  logic [tthc_pkg::WideW-1:0] nnum9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec9_q  <= sec8_q;
      px9_q   <= px8_q;
      py9_q   <= py8_q;
      lv9_q   <= lv8_q;
      lm9_q   <= lm8_q;
      nnum9_q <= tthc_pkg::WideW'(py8_q) *
                 tthc_pkg::WideW'(PW'(tthc_pkg::HsvFull) - satg8_q);
    end
  end

  // stage 10: first division by full scale
  logic v10_q;
  logic [SW-1:0] sec10_q;
  logic [CW-1:0] px10_q, py10_q;
  logic [LW-1:0] lv10_q, lm10_q;
  logic [PW-1:0] n1_10_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec10_q <= sec9_q;
      px10_q  <= px9_q;
      py10_q  <= py9_q;
      lv10_q  <= lv9_q;
      lm10_q  <= lm9_q;
      n1_10_q <= tthc_pkg::div1023(nnum9_q);
    end
  end

  // output stage: second division and sector select
  logic [PW-1:0] nq;
  logic [LW-1:0] ln;
  logic [LW-1:0] rd, gr, bl;
  logic out_vld_q;
  logic [55:0] out_data_q;

  assign nq = tthc_pkg::div1023(tthc_pkg::WideW'(n1_10_q));
  assign ln = nq[LW-1:0];

  always_comb begin
    case (sec10_q)
      3'd0: begin rd = lv10_q; gr = ln;     bl = lm10_q; end
      3'd1: begin rd = ln;     gr = lv10_q; bl = lm10_q; end
      3'd2: begin rd = lm10_q; gr = lv10_q; bl = ln;     end
      3'd3: begin rd = lm10_q; gr = ln;     bl = lv10_q; end
      3'd4: begin rd = ln;     gr = lm10_q; bl = lv10_q; end
      default: begin rd = lv10_q; gr = lm10_q; bl = ln; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {6'b0, bl, 2'b0, gr, 2'b0, rd, 2'b0, py10_q, px10_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      vdiv_q    <= '0;
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_acc && in_win;
      vdiv_q    <= {vdiv_q[DS-2:0], v1_q};
      v7_q      <= vdiv_q[DS-1];
      v8_q      <= v7_q;
      v9_q      <= v8_q;
      v10_q     <= v9_q;
      out_vld_q <= v10_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
